FILE: hw/rtl/ffcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffcm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // view_mode codes; the spare code falls through to vorticity
  localparam logic [1:0] MODE_PRESSURE = 2'd0;
  localparam logic [1:0] MODE_SPEED    = 2'd1;
  localparam logic [1:0] MODE_VORT     = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
  } ctl_t;

  typedef struct packed {
    logic [1:0]  view_mode;
    logic [31:0] reference_density;
    logic [31:0] pressure_scale;
    logic [31:0] speed_scale;
    logic [31:0] vorticity_scale;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffcm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ffcm_front #(
  parameter int FRAC_BITS = ffcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire ffcm_pkg::cfg_t     cfg,
  input  wire logic               cell_valid,
  input  wire logic [31:0]        density,
  input  wire logic [31:0]        vel_x,
  input  wire logic [31:0]        vel_y,
  input  wire logic [31:0]        vel_y_east,
  input  wire logic [31:0]        vel_y_west,
  input  wire logic [31:0]        vel_x_north,
  input  wire logic [31:0]        vel_x_south,
  input  wire logic               edge_or_solid,
  output logic [63:0]             sum_o,
  output logic [FRAC_BITS:0]      t_o,
  output ffcm_pkg::ctl_t          ctl_o
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int TLW = FRAC_BITS + 4;
  localparam int SW  = FRAC_BITS + 6;
  localparam int XW  = FRAC_BITS + 2;
  localparam int K2  = FRAC_BITS + 3;
  localparam int MW  = 2 * FRAC_BITS + 4;
  localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF  = ONE >> 1;
  localparam logic [63:0] TWO   = ONE << 1;
  localparam logic [63:0] THREE = ONE * 64'd3;
  localparam logic [63:0] LIM   = ONE << 3;
  // ceil(2^34/3): exact floor(x/3) for x below 2^33
  localparam logic [32:0] M3A   = 33'd5726623062;
  // ceil(2^K2/3): exact floor(x/3) for x below 2^(FRAC_BITS+2)
  localparam logic [63:0] M3B   = ((64'd1 << K2) + 64'd2) / 64'd3;

  // F0
  ffcm_pkg::ctl_t      ctl0;
  logic [62:0]         sqx0, sqy0;
  logic signed [33:0]  diff0, w20;
  logic                edge0;
  // F1
  ffcm_pkg::ctl_t      ctl1;
  logic [63:0]         sum1;
  logic [49:0]         plo1;
  logic [48:0]         phi1;
  logic                pneg1, vneg1, edge1;
  logic [31:0]         hm1;
  // F2
  ffcm_pkg::ctl_t      ctl2;
  logic [63:0]         sum2;
  logic [31:0]         q2;
  logic [63:0]         vprod2;
  logic                pneg2, vneg2, edge2;
  // F3
  ffcm_pkg::ctl_t      ctl3;
  logic [63:0]         sum3, pprod3;
  logic                pneg3;
  logic [TW-1:0]       tv3;
  // F4
  ffcm_pkg::ctl_t      ctl4;
  logic [63:0]         sum4;
  logic [XW-1:0]       x4;
  logic [TW-1:0]       tv4;

  logic signed [63:0]  sqx_full, sqy_full;
  logic signed [32:0]  dy, dx;
  logic signed [33:0]  dmag, wabs;
  logic [65:0]         full3;
  logic [63:0]         pv, pp;
  logic [TLW-1:0]      pvc, pc;
  logic signed [SW-1:0] tvs, ps;
  logic [TW-1:0]       tv_next;
  logic [XW-1:0]       x_next;
  logic [MW-1:0]       tprod;

  always_comb begin
    sqx_full = $signed(vel_x) * $signed(vel_x);
    sqy_full = $signed(vel_y) * $signed(vel_y);
    dy = $signed({vel_y_east[31], vel_y_east}) - $signed({vel_y_west[31], vel_y_west});
    dx = $signed({vel_x_north[31], vel_x_north}) - $signed({vel_x_south[31], vel_x_south});

    dmag = diff0[33] ? -diff0 : diff0;
    wabs = w20[33] ? -w20 : w20;

    full3 = 66'(plo1) + (66'(phi1) << 17);

    // vorticity term, limited to +-8 then offset by one half
    pv  = vprod2 >> FRAC_BITS;
    pvc = (pv > LIM) ? LIM[TLW-1:0] : pv[TLW-1:0];
    tvs = $signed(SW'(HALF)) + (vneg2 ? -$signed(SW'(pvc)) : $signed(SW'(pvc)));
    if (edge2) begin
      tv_next = HALF[TW-1:0];
    end else if (tvs < 0) begin
      tv_next = '0;
    end else if (tvs > $signed(SW'(ONE))) begin
      tv_next = ONE[TW-1:0];
    end else begin
      tv_next = tvs[TW-1:0];
    end

    // Cp + 2, clamped to [0,3] ahead of the divide
    pp = pprod3 >> FRAC_BITS;
    pc = (pp > LIM) ? LIM[TLW-1:0] : pp[TLW-1:0];
    ps = $signed(SW'(TWO)) + (pneg3 ? -$signed(SW'(pc)) : $signed(SW'(pc)));
    if (ps <= 0) begin
      x_next = '0;
    end else if (ps >= $signed(SW'(THREE))) begin
      x_next = THREE[XW-1:0];
    end else begin
      x_next = ps[XW-1:0];
    end

    tprod = MW'(x4) * MW'(M3B);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
      ctl_o <= '0;
    end else if (en) begin
      ctl0 <= '{valid: cell_valid, mode: cfg.view_mode};
      ctl1 <= ctl0;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl_o <= ctl4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx0  <= sqx_full[62:0];
      sqy0  <= sqy_full[62:0];
      diff0 <= $signed({{2{density[31]}}, density})
             - $signed({2'b00, cfg.reference_density});
      w20   <= $signed({dy[32], dy}) - $signed({dx[32], dx});
      edge0 <= edge_or_solid;

      sum1  <= {1'b0, sqx0} + {1'b0, sqy0};
      plo1  <= 50'(dmag[16:0]) * 50'(M3A);
      phi1  <= 49'(dmag[32:17]) * 49'(M3A);
      pneg1 <= diff0[33];
      hm1   <= wabs[32:1];
      vneg1 <= w20[33];
      edge1 <= edge0;

      sum2   <= sum1;
      q2     <= full3[65:34];
      pneg2  <= pneg1;
      vprod2 <= 64'(hm1) * 64'(cfg.vorticity_scale);
      vneg2  <= vneg1;
      edge2  <= edge1;

      sum3   <= sum2;
      pprod3 <= 64'(q2) * 64'(cfg.pressure_scale);
      pneg3  <= pneg2;
      tv3    <= tv_next;

      sum4 <= sum3;
      x4   <= x_next;
      tv4  <= tv3;

      sum_o <= sum4;
      t_o   <= (ctl4.mode == ffcm_pkg::MODE_PRESSURE) ? tprod[K2 +: TW] : tv4;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ffcm_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module ffcm_sqrt #(
  parameter int FRAC_BITS = ffcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [63:0]        sum,
  input  wire logic [FRAC_BITS:0] t_in,
  input  wire ffcm_pkg::ctl_t     ctl_in,
  output logic [31:0]             root,
  output logic [FRAC_BITS:0]      t_out,
  output ffcm_pkg::ctl_t          ctl_out
);

  localparam int TW     = FRAC_BITS + 1;
  localparam int STEPS  = 2;
  localparam int STAGES = 32 / STEPS;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } sq_t;

  // one result digit: remainder stays below 2^33 before each step
  function automatic sq_t sq_step(sq_t s);
    sq_t         n;
    logic [34:0] r;
    logic [34:0] trial;
    r     = {s.rem[32:0], s.x[63:62]};
    trial = {1'b0, s.root, 2'b01};
    n.x   = {s.x[61:0], 2'b00};
    if (r >= trial) begin
      n.rem  = r - trial;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = r;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  sq_t            st_q  [STAGES];
  logic [TW-1:0]  t_q   [STAGES];
  ffcm_pkg::ctl_t ctl_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    sq_t            st_in, st_next;
    logic [TW-1:0]  tin;
    ffcm_pkg::ctl_t cin;

    if (i == 0) begin : g_first
      assign st_in = {35'd0, 32'd0, sum};
      assign tin   = t_in;
      assign cin   = ctl_in;
    end else begin : g_next
      assign st_in = st_q[i-1];
      assign tin   = t_q[i-1];
      assign cin   = ctl_q[i-1];
    end

    always_comb begin
      st_next = st_in;
      for (int k = 0; k < STEPS; k++) begin
        st_next = sq_step(st_next);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[i] <= '0;
      end else if (en) begin
        ctl_q[i] <= cin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_q[i] <= st_next;
        t_q[i]  <= tin;
      end
    end
  end

  assign root    = st_q[STAGES-1].root;
  assign t_out   = t_q[STAGES-1];
  assign ctl_out = ctl_q[STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ffcm_colour.sv
`timescale 1ns / 1ps
`default_nettype none

module ffcm_colour #(
  parameter int FRAC_BITS = ffcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [31:0]        speed_scale,
  input  wire logic [31:0]        root,
  input  wire logic [FRAC_BITS:0] t_in,
  input  wire ffcm_pkg::ctl_t     ctl_in,
  output logic                    pixel_valid,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  localparam int TW = FRAC_BITS + 1;
  localparam int KW = FRAC_BITS + 2;
  localparam int PW = 2 * KW;
  localparam int CW = FRAC_BITS + 4;
  localparam int EW = FRAC_BITS + 9;
  localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF = ONE >> 1;
  localparam logic [63:0] J15  = (ONE * 64'd3) >> 1;
  localparam logic [63:0] J18  = ONE >> 3;
  localparam logic [63:0] J78  = (ONE * 64'd7) >> 3;
  localparam logic [63:0] J055 = ((64'd11 << FRAC_BITS) + 64'd10) / 64'd20;
  localparam logic [63:0] J36  = ((64'd18 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [63:0] J16  = ((64'd8 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [63:0] D12  = ((64'd12 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D85  = ((64'd85 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D22  = ((64'd22 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D75  = ((64'd75 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D83  = ((64'd83 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D14  = ((64'd14 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D97  = ((64'd97 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D18  = ((64'd18 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] D88  = ((64'd88 << FRAC_BITS) + 64'd50) / 64'd100;

  function automatic logic signed [CW-1:0] sc(logic [63:0] v);
    return $signed(CW'(v));
  endfunction

  // nonnegative Q product, truncated
  function automatic logic signed [CW-1:0] mulq(logic [KW-1:0] a, logic [63:0] k);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(k[KW-1:0]);
    return $signed(CW'(p >> FRAC_BITS));
  endfunction

  function automatic logic signed [CW-1:0] clamp01(logic signed [CW-1:0] v);
    if (v < 0) return '0;
    if (v > sc(ONE)) return sc(ONE);
    return v;
  endfunction

  function automatic logic [7:0] to8(logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    logic [EW-1:0]        e;
    c = clamp01(v);
    e = EW'(c[CW-2:0]) * EW'(255) + EW'(HALF);
    return e[FRAC_BITS +: 8];
  endfunction

  ffcm_pkg::ctl_t       ctl0, ctl1, ctl2;
  logic [63:0]          sprod0;
  logic [TW-1:0]        t0, t1;
  logic signed [CW-1:0] r2, g2, b2;

  logic [63:0]          sp;
  logic [TW-1:0]        ts;
  logic signed [CW-1:0] t4, ar, ag, ab;
  logic signed [CW-1:0] jr, jg, jb, dr, dg, db;
  logic [KW-1:0]        u;
  logic                 use_jet;

  always_comb begin
    sp = sprod0 >> FRAC_BITS;
    ts = (sp > ONE) ? ONE[TW-1:0] : sp[TW-1:0];

    t4 = sc(64'(t1)) <<< 2;
    ar = t4 - sc(ONE * 64'd3);
    ag = t4 - sc(ONE * 64'd2);
    ab = t4 - sc(ONE);
    jr = clamp01(sc(J15) - (ar < 0 ? -ar : ar));
    jg = clamp01(sc(J15) - (ag < 0 ? -ag : ag));
    jb = clamp01(sc(J15) - (ab < 0 ? -ab : ab));
    // darkened ends of the jet map
    if (64'(t1) < J18) begin
      jb = sc(J055) + mulq(KW'(t1), J36);
    end
    if (64'(t1) > J78) begin
      jr = sc(ONE) - mulq(KW'(64'(t1) - J78), J16);
    end

    if (64'(t1) < HALF) begin
      u  = KW'(t1) << 1;
      dr = sc(D12) + mulq(u, D85);
      dg = sc(D22) + mulq(u, D75);
      db = sc(D83) + mulq(u, D14);
    end else begin
      u  = KW'(64'(t1) - HALF) << 1;
      dr = sc(D97) - mulq(u, D18);
      dg = sc(D97) - mulq(u, D88);
      db = sc(D97) - mulq(u, D85);
    end

    use_jet = (ctl1.mode == ffcm_pkg::MODE_PRESSURE) || (ctl1.mode == ffcm_pkg::MODE_SPEED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
      ctl1 <= '0;
      ctl2 <= '0;
      pixel_valid <= 1'b0;
    end else if (en) begin
      ctl0 <= ctl_in;
      ctl1 <= ctl0;
      ctl2 <= ctl1;
      pixel_valid <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sprod0 <= 64'(root) * 64'(speed_scale);
      t0     <= t_in;
      t1     <= (ctl0.mode == ffcm_pkg::MODE_SPEED) ? ts : t0;
      r2     <= use_jet ? jr : dr;
      g2     <= use_jet ? jg : dg;
      b2     <= use_jet ? jb : db;
      red    <= to8(r2);
      green  <= to8(g2);
      blue   <= to8(b2);
    end
  end

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    ctl1.valid |-> (64'(t1) <= ONE))
    else $error("colour scale above one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(t1) && $stable(ctl1) && $stable(r2)))
    else $error("stage changed while frozen");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (en && ctl2.valid) |=> pixel_valid)
    else $error("word lost in final stage");

endmodule

`default_nettype wire

FILE: hw/rtl/flow_field_colormap_pixel_unit.sv
// From cell word accepted to pixel word valid, words pass through
//   6 front stages, 16 square-root stages and 4 colour stages.
// Throughput: one cell per cycle when not stalled; 16 square-root stages, two digits each.
// A stall on a valid pixel word freezes the whole pipeline and stalls the cell side.
// Reset (rst, synchronous) clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module flow_field_colormap_pixel_unit #(
  parameter int FRAC_BITS = ffcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cell_valid,
  output logic             cell_stall,
  input  wire logic [31:0] density,
  input  wire logic [31:0] vel_x,
  input  wire logic [31:0] vel_y,
  input  wire logic [31:0] vel_y_east,
  input  wire logic [31:0] vel_y_west,
  input  wire logic [31:0] vel_x_north,
  input  wire logic [31:0] vel_x_south,
  input  wire logic        edge_or_solid,
  output logic             pixel_valid,
  input  wire logic        pixel_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [2:0] REG_VIEW_MODE = 3'd0;
  localparam logic [2:0] REG_REF_DENS  = 3'd1;
  localparam logic [2:0] REG_P_SCALE   = 3'd2;
  localparam logic [2:0] REG_S_SCALE   = 3'd3;
  localparam logic [2:0] REG_V_SCALE   = 3'd4;
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  ffcm_pkg::cfg_t cfg;
  logic           en;

  logic [63:0]         f_sum;
  logic [FRAC_BITS:0]  f_t, s_t;
  ffcm_pkg::ctl_t      f_ctl, s_ctl;
  logic [31:0]         s_root;

  assign cfg_ready  = 1'b1;
  assign en         = !(pixel_valid && pixel_stall);
  assign cell_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_mode         <= ffcm_pkg::MODE_PRESSURE;
      cfg.reference_density <= ONE;
      cfg.pressure_scale    <= ONE;
      cfg.speed_scale       <= ONE;
      cfg.vorticity_scale   <= ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VIEW_MODE: cfg.view_mode         <= cfg_data[1:0];
        REG_REF_DENS:  cfg.reference_density <= cfg_data;
        REG_P_SCALE:   cfg.pressure_scale    <= cfg_data;
        REG_S_SCALE:   cfg.speed_scale       <= cfg_data;
        REG_V_SCALE:   cfg.vorticity_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  ffcm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en, .cfg, .cell_valid,
    .density, .vel_x, .vel_y, .vel_y_east, .vel_y_west,
    .vel_x_north, .vel_x_south, .edge_or_solid,
    .sum_o(f_sum), .t_o(f_t), .ctl_o(f_ctl)
  );

  ffcm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst, .en,
    .sum(f_sum), .t_in(f_t), .ctl_in(f_ctl),
    .root(s_root), .t_out(s_t), .ctl_out(s_ctl)
  );

  ffcm_colour #(.FRAC_BITS(FRAC_BITS)) u_colour (
    .clk, .rst, .en,
    .speed_scale(cfg.speed_scale),
    .root(s_root), .t_in(s_t), .ctl_in(s_ctl),
    .pixel_valid, .red, .green, .blue
  );

endmodule

`default_nettype wire
